// ----- rtl/multilevel_priority_queue_macros.svh -----
// assertion macros for the multilevel priority queue
// used by the top level only; no other dependencies
`ifndef MULTILEVEL_PRIORITY_QUEUE_MACROS_SVH
`define MULTILEVEL_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MLPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MLPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mlpq_pkg.sv -----
// shared types, constants and helpers for the multilevel priority queue
// no dependencies
package mlpq_pkg;

  // sizing
  localparam int LEVELS      = 16;
  localparam int LEVEL_DEPTH = 16;
  localparam int HANDLE_W    = 16;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int HELD_W = $clog2(LEVELS * LEVEL_DEPTH + 1);
  localparam int ADDR_W = $clog2(LEVELS * LEVEL_DEPTH);

  // fixed field widths of the transaction payloads
  localparam int PRIO_FIELD_W  = 4;
  localparam int LEVEL_FIELD_W = 4;
  localparam int COUNT_FIELD_W = 9;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_TAKE,
    S_FRONT
  } fsm_t;

  typedef struct packed {
    action_t                   action;
    logic [HANDLE_W-1:0]       item_handle;
    logic [PRIO_FIELD_W-1:0]   priority_req;
  } in_item_t;

  typedef struct packed {
    status_t                    status;
    logic                       taken_valid;
    logic [HANDLE_W-1:0]        taken_item;
    logic [LEVEL_FIELD_W-1:0]   taken_level;
    logic                       front_valid;
    logic [HANDLE_W-1:0]        front_item;
    logic                       all_empty;
    logic [COUNT_FIELD_W-1:0]   total_count;
  } out_item_t;

  // result of the shared level picker
  typedef struct packed {
    logic             found;
    logic [LVL_W-1:0] level;
  } pick_t;

  // request to the entry store
  typedef struct packed {
    logic                we;
    logic                re;
    logic [ADDR_W-1:0]   addr;
    logic [HANDLE_W-1:0] wdata;
  } mem_req_t;

  // circular pointer advance within one level
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  // flat entry address of a slot in a level
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lv,
                                                  input logic [PTR_W-1:0] p);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(lv) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(p);
    return a;
  endfunction

endpackage

// ----- rtl/mlpq_pick.sv -----
// level picker: lowest-numbered level that holds an item
// depends on mlpq_pkg
module mlpq_pick import mlpq_pkg::*; (
  input  logic [LEVELS-1:0] nonempty,
  output pick_t             pick
);

  // priority encoder, level 0 wins
  always_comb begin
    pick.found = 1'b0;
    pick.level = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        pick.found = 1'b1;
        pick.level = LVL_W'(i);
      end
    end
  end

endmodule

// ----- rtl/mlpq_store.sv -----
// entry store: one port, one access per cycle, registered read data
// depends on mlpq_pkg
module mlpq_store import mlpq_pkg::*; (
  input  logic                clk,
  input  mem_req_t            req,
  output logic [HANDLE_W-1:0] rdata_r
);

  logic [HANDLE_W-1:0] mem [LEVELS * LEVEL_DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

endmodule

// ----- rtl/multilevel_priority_queue.sv -----
// Multilevel priority queue: one bounded FIFO per level, level 0 first.
// A transaction is accepted when start is high and busy is low; the
// result is strobed on out_valid for one cycle, in state S_FRONT after
// states S_OP and S_TAKE, and the receiver cannot stall it. busy stays high
// from acceptance through the result cycle, so transactions never overlap;
// this follows from the single port of the entry store: each transaction
// makes one access to enqueue or fetch the taken item and one more to fetch
// the new front. A dequeue on an empty queue reports status empty, an
// enqueue to a full level reports status full; both leave the queue
// unchanged. No clearing pass is needed after reset.
// depends on mlpq_pkg, mlpq_pick, mlpq_store and the assertion macros
`include "multilevel_priority_queue_macros.svh"

module multilevel_priority_queue import mlpq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  fsm_t state_r, state_nxt;

  // latched transaction
  action_t             act_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [LVL_W-1:0]    lv_r;

  // per-level queue state
  logic [PTR_W-1:0]  head_r  [LEVELS];
  logic [PTR_W-1:0]  tail_r  [LEVELS];
  logic [CNT_W-1:0]  count_r [LEVELS];
  logic [HELD_W-1:0] held_r;

  // result registers
  status_t             status_r;
  logic                taken_valid_r;
  logic [LVL_W-1:0]    taken_level_r;
  logic [HANDLE_W-1:0] taken_item_r;
  logic                front_valid_r;

  logic [LEVELS-1:0]   nonempty;
  pick_t               pick;
  logic [LVL_W-1:0]    cur_lv;
  logic [PTR_W-1:0]    head_cur, tail_cur;
  logic [CNT_W-1:0]    count_cur;
  logic                enq_ok, deq_ok, accept;
  mem_req_t            mem_req;
  logic [HANDLE_W-1:0] rdata;
  logic                deq_miss, refused;

  assign accept = start && (state_r == S_IDLE);

  // non-empty flags feed the shared picker
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      nonempty[i] = (count_r[i] != '0);
    end
  end

  mlpq_pick u_pick (
    .nonempty (nonempty),
    .pick     (pick)
  );

  // one level is worked on per cycle
  assign cur_lv    = (state_r == S_OP && act_r == ACT_ENQ) ? lv_r : pick.level;
  assign head_cur  = head_r[cur_lv];
  assign tail_cur  = tail_r[cur_lv];
  assign count_cur = count_r[cur_lv];

  assign enq_ok = (state_r == S_OP) && (act_r == ACT_ENQ) &&
                  (count_cur != CNT_W'(LEVEL_DEPTH));
  assign deq_ok = (state_r == S_OP) && (act_r == ACT_DEQ) && pick.found;

  // entry store access
  always_comb begin
    mem_req.we    = enq_ok;
    mem_req.re    = deq_ok || ((state_r == S_TAKE) && pick.found);
    mem_req.addr  = slot_addr(cur_lv, enq_ok ? tail_cur : head_cur);
    mem_req.wdata = handle_r;
  end

  mlpq_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rdata_r (rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_OP;
      S_OP:    state_nxt = S_TAKE;
      S_TAKE:  state_nxt = S_FRONT;
      S_FRONT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // handshake outputs
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE:  busy = 1'b0;
      S_FRONT: out_valid = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // capture the transaction, level saturated to the last one
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_data.action;
      handle_r <= in_data.item_handle;
      lv_r     <= (int'(in_data.priority_req) >= LEVELS) ?
                  LVL_W'(LEVELS - 1) : LVL_W'(in_data.priority_req);
    end
  end

  // queue bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        count_r[i] <= '0;
      end
      held_r <= '0;
    end else if (enq_ok) begin
      tail_r[cur_lv]  <= ptr_inc(tail_cur);
      count_r[cur_lv] <= count_cur + 1'b1;
      held_r          <= held_r + 1'b1;
    end else if (deq_ok) begin
      head_r[cur_lv]  <= ptr_inc(head_cur);
      count_r[cur_lv] <= count_cur - 1'b1;
      held_r          <= held_r - 1'b1;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (state_r == S_OP) begin
      taken_valid_r <= deq_ok;
      taken_level_r <= deq_ok ? cur_lv : '0;
      if (act_r == ACT_ENQ) begin
        status_r <= enq_ok ? ST_OK : ST_FULL;
      end else begin
        status_r <= deq_ok ? ST_OK : ST_EMPTY;
      end
    end
    if (state_r == S_TAKE) begin
      taken_item_r  <= taken_valid_r ? rdata : '0;
      front_valid_r <= pick.found;
    end
  end

  always_comb begin
    out_data.status      = status_r;
    out_data.taken_valid = taken_valid_r;
    out_data.taken_item  = taken_item_r;
    out_data.taken_level = LEVEL_FIELD_W'(taken_level_r);
    out_data.front_valid = front_valid_r;
    out_data.front_item  = front_valid_r ? rdata : '0;
    out_data.all_empty   = (held_r == '0);
    out_data.total_count = COUNT_FIELD_W'(held_r);
  end

  // checks
  assign deq_miss = (state_r == S_OP) && (act_r == ACT_DEQ) && !pick.found;
  assign refused  = out_valid && (out_data.status != ST_OK);

  `MLPQ_ASSERT_NOW(a_result_timing, clk, rst_n, accept, ##3 out_valid, "late result")
  `MLPQ_ASSERT_NOW(a_empty_means_zero, clk, rst_n, deq_miss, held_r == '0, "missed items")
  `MLPQ_ASSERT_NEXT(a_enq_counts, clk, rst_n, enq_ok, held_r == $past(held_r) + 1'b1, "no count")
  `MLPQ_ASSERT_NOW(a_full_takes_nothing, clk, rst_n, refused, !out_data.taken_valid, "taken")

endmodule
